FILE: rtl/core/dma_controller_register_file_assert.svh
// assertion macros shared by the dma register file modules
// expects aclk and aresetn in the scope of each use
`ifndef DMA_CONTROLLER_REGISTER_FILE_ASSERT_SVH
`define DMA_CONTROLLER_REGISTER_FILE_ASSERT_SVH

// same-cycle implication
`define DCRF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("dcrf assertion failed");

// next-cycle implication
`define DCRF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("dcrf assertion failed");

`endif

FILE: rtl/core/dcrf_pkg.sv
// types and constants of the dma controller register file
// no dependencies
`timescale 1ns / 1ps

package dcrf_pkg;

    localparam int NUM_CHANNELS = 7;
    localparam int CH_W = 3;

    localparam logic [6:0] OFF_OTC_CTRL = 7'h68;
    localparam logic [6:0] OFF_PRIO     = 7'h70;
    localparam logic [6:0] OFF_IRQ      = 7'h74;

    localparam logic [3:0] REG_OFF_ADDR  = 4'h0;
    localparam logic [3:0] REG_OFF_BLOCK = 4'h4;
    localparam logic [3:0] REG_OFF_CTRL  = 4'h8;

    localparam logic [CH_W-1:0] CH_NONE = 3'd7;
    localparam logic [CH_W-1:0] CH_OTC  = 3'd6;

    localparam logic [31:0] PRIO_RESET     = 32'h0765_4321;
    localparam logic [31:0] OTC_WRITE_MASK = 32'h5100_0000;
    localparam logic [31:0] CTL_WRITE_MASK = 32'h7177_0703;
    localparam logic [31:0] CTL_DONE_CLEAR = 32'h1100_0000;
    localparam logic [31:0] OTC_FORCED     = 32'h0000_0002;
    localparam logic [31:0] IRQ_KEEP_MASK  = 32'hff00_0000;
    localparam logic [31:0] IRQ_ACK_MASK   = 32'h7f00_0000;
    localparam logic [31:0] IRQ_WRITE_MASK = 32'h00ff_803f;

    // channels that can run a transfer: 0, 2, 3, 4 and otc
    localparam logic [NUM_CHANNELS-1:0] START_MASK = 7'b101_1101;

    localparam logic [1:0] MODE_MANUAL = 2'd0;
    localparam logic [1:0] MODE_BLOCK  = 2'd1;

    typedef logic [2:0] sel_t;
    localparam sel_t SEL_ADDR  = 3'd0;
    localparam sel_t SEL_BLOCK = 3'd1;
    localparam sel_t SEL_CTRL  = 3'd2;
    localparam sel_t SEL_OTC   = 3'd3;
    localparam sel_t SEL_PRIO  = 3'd4;
    localparam sel_t SEL_IRQ   = 3'd5;
    localparam sel_t SEL_BAD   = 3'd6;

    typedef struct packed {
        logic            is_write;
        sel_t            sel;
        logic [CH_W-1:0] ch;
    } acc_t;

    typedef struct packed {
        logic [31:0]     rdata;
        logic            irq_level;
        logic            irq_rise;
        logic            start_valid;
        logic [CH_W-1:0] start_channel;
        logic            start_direction;
        logic [1:0]      start_sync_mode;
        logic            start_backward;
        logic [23:0]     start_address;
        logic [31:0]     start_words;
        logic            error;
    } res_t;

endpackage

FILE: rtl/core/dcrf_decode.sv
// address decode of one bus access into a register select and channel
// depends on dcrf_pkg
`timescale 1ns / 1ps

module dcrf_decode
    import dcrf_pkg::*;
(
    input  logic       func,
    input  logic [6:0] offset,
    output acc_t       acc
);

    logic [CH_W-1:0] ch;
    logic [3:0]      reg_off;

    assign ch      = offset[6:4];
    assign reg_off = offset[3:0];

    always_comb begin
        acc.is_write = func;
        acc.sel      = SEL_BAD;
        if (offset == OFF_PRIO) begin
            acc.sel = SEL_PRIO;
        end else if (offset == OFF_IRQ) begin
            acc.sel = SEL_IRQ;
        end else if (func && offset == OFF_OTC_CTRL) begin
            acc.sel = SEL_OTC;
        end else if (ch != CH_NONE) begin
            case (reg_off)
                REG_OFF_ADDR:  acc.sel = SEL_ADDR;
                REG_OFF_BLOCK: acc.sel = SEL_BLOCK;
                REG_OFF_CTRL:  acc.sel = SEL_CTRL;
                default:       acc.sel = SEL_BAD;
            endcase
        end
        // keep the array index inside the channel range
        acc.ch = (ch == CH_NONE) ? '0 : ch;
    end

endmodule

FILE: rtl/core/dcrf_core.sv
// channel, priority and interrupt registers with the access result logic
// depends on dcrf_pkg and dma_controller_register_file_assert.svh
`timescale 1ns / 1ps
`include "dma_controller_register_file_assert.svh"

module dcrf_core
    import dcrf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        proc,
    input  acc_t        acc,
    input  logic [31:0] wdata,
    output res_t        res
);

    logic [23:0] addr_reg [NUM_CHANNELS];
    logic [31:0] block_reg [NUM_CHANNELS];
    logic [31:0] ctrl_reg [NUM_CHANNELS];
    logic [31:0] prio_reg;
    logic [31:0] irq_reg;

    logic [31:0] ctrl_next;
    logic [31:0] irq_next;
    logic [31:0] ctl_new;
    logic [31:0] irq_tmp;
    logic [31:0] blk;
    logic [31:0] prod;
    logic [NUM_CHANNELS-1:0] irq_en;
    logic [1:0]  mode;
    logic        start_req;
    logic        fire;
    logic        refresh;
    logic        lvl;

    assign blk    = block_reg[acc.ch];
    assign prod   = blk[15:0] * blk[31:16];
    assign irq_en = irq_reg[16 +: NUM_CHANNELS];

    always_comb begin
        if (acc.sel == SEL_OTC) begin
            ctl_new = (wdata & OTC_WRITE_MASK) | OTC_FORCED;
        end else begin
            ctl_new = wdata & CTL_WRITE_MASK;
        end
        mode = ctl_new[10:9];

        start_req = 1'b0;
        if (acc.is_write && acc.sel == SEL_OTC) begin
            start_req = ctl_new[24] && ctl_new[28];
        end else if (acc.is_write && acc.sel == SEL_CTRL) begin
            start_req = ctl_new[24] && (ctl_new[28] || mode != MODE_MANUAL);
        end
        fire = start_req && START_MASK[acc.ch];

        ctrl_next = fire ? (ctl_new & ~CTL_DONE_CLEAR) : ctl_new;

        // interrupt register update, then level refresh on an irq write or on a start that sets a flag
        refresh = 1'b0;
        irq_tmp = irq_reg;
        if (acc.is_write && acc.sel == SEL_IRQ) begin
            irq_tmp = ((irq_reg & IRQ_KEEP_MASK) & ~(wdata & IRQ_ACK_MASK))
                      | (wdata & IRQ_WRITE_MASK);
            refresh = 1'b1;
        end else if (fire && irq_en[acc.ch]) begin
            irq_tmp[24 +: NUM_CHANNELS] = irq_reg[24 +: NUM_CHANNELS]
                | (NUM_CHANNELS'(1) << acc.ch);
            refresh = 1'b1;
        end
        lvl = irq_tmp[15] | (irq_tmp[23] & (|(irq_tmp[22:16] & irq_tmp[30:24])));
        irq_next = {refresh ? lvl : irq_tmp[31], irq_tmp[30:0]};

        res = '0;
        if (!acc.is_write) begin
            case (acc.sel)
                SEL_PRIO:  res.rdata = prio_reg;
                SEL_IRQ:   res.rdata = irq_reg;
                SEL_ADDR:  res.rdata = {8'd0, addr_reg[acc.ch]};
                SEL_BLOCK: res.rdata = blk;
                SEL_CTRL:  res.rdata = ctrl_reg[acc.ch];
                default:   res.rdata = '0;
            endcase
        end
        res.irq_level = irq_next[31];
        res.irq_rise  = refresh & ~irq_tmp[31] & lvl;
        res.error     = (acc.sel == SEL_BAD) || (start_req && !fire);
        if (fire) begin
            res.start_valid     = 1'b1;
            res.start_channel   = acc.ch;
            res.start_direction = ctl_new[0];
            res.start_sync_mode = mode;
            res.start_backward  = ctl_new[1];
            res.start_address   = addr_reg[acc.ch];
            case (mode)
                MODE_MANUAL: res.start_words = {16'd0, blk[15:0]};
                MODE_BLOCK:  res.start_words = prod;
                default:     res.start_words = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                addr_reg[i]  <= '0;
                block_reg[i] <= '0;
                ctrl_reg[i]  <= '0;
            end
            prio_reg <= PRIO_RESET;
            irq_reg  <= '0;
        end else if (proc) begin
            irq_reg <= irq_next;
            if (acc.is_write) begin
                case (acc.sel)
                    SEL_ADDR:  addr_reg[acc.ch]  <= wdata[23:0];
                    SEL_BLOCK: block_reg[acc.ch] <= wdata;
                    SEL_CTRL:  ctrl_reg[acc.ch]  <= ctrl_next;
                    SEL_OTC:   ctrl_reg[acc.ch]  <= ctrl_next;
                    SEL_PRIO:  prio_reg          <= wdata;
                    default:   ;
                endcase
            end
        end
    end

    `DCRF_ASSERT_NOW(a_irq_level_consistent, 1'b1,
        irq_reg[31] == (irq_reg[15] | (irq_reg[23] & (|(irq_reg[22:16] & irq_reg[30:24])))))
    `DCRF_ASSERT_NEXT(a_start_clears_enable, proc && fire && acc.ch == CH_OTC,
        !ctrl_reg[CH_OTC][24])
    `DCRF_ASSERT_NOW(a_error_no_start, proc && res.error, !res.start_valid)

endmodule

FILE: rtl/core/dma_controller_register_file.sv
// channel          | direction | accepted when      | payload
// s_ (bus access)  | in        | s_tvalid&s_tready  | tuser func, tdata offset/wdata
// m_ (access res.) | out       | m_tvalid&m_tready  | tuser flags, tdata read/start data
// one access per cycle sustained while m_tready holds; an item waits in the input register
// until it can advance, and its result is then registered into the output register
// register updates happen on the edge the item leaves the input register
// the input side keeps taking items while a result waits, until both stages are full
// synchronous active-low reset restores core regs and valid flags; no clearing pass
// top level of the dma controller register file
// depends on dcrf_pkg, dcrf_decode, dcrf_core and the assertion macro header
`timescale 1ns / 1ps
`include "dma_controller_register_file_assert.svh"

module dma_controller_register_file
    import dcrf_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // offset[6:0], wdata[38:7], zero pad
    input  logic         s_tuser,   // func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // rdata, irq_level, irq_rise, start_channel,
                                    // start_direction, start_sync_mode, start_backward,
                                    // start_address, start_words, zero pad
    output logic [1:0]   m_tuser    // start_valid, error
);

    logic        in_vld_reg;
    logic        in_func_reg;
    logic [6:0]  in_off_reg;
    logic [31:0] in_wdata_reg;
    logic        out_vld_reg;
    res_t        out_res_reg;
    logic        advance;
    acc_t        acc;
    res_t        res;

    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    dcrf_decode u_decode (
        .func   (in_func_reg),
        .offset (in_off_reg),
        .acc    (acc)
    );

    dcrf_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .proc    (advance),
        .acc     (acc),
        .wdata   (in_wdata_reg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_vld_reg <= s_tvalid;
            end
            if (advance) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_func_reg  <= s_tuser;
            in_off_reg   <= s_tdata[6:0];
            in_wdata_reg <= s_tdata[38:7];
        end
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'd0,
                       out_res_reg.start_words,
                       out_res_reg.start_address,
                       out_res_reg.start_backward,
                       out_res_reg.start_sync_mode,
                       out_res_reg.start_direction,
                       out_res_reg.start_channel,
                       out_res_reg.irq_rise,
                       out_res_reg.irq_level,
                       out_res_reg.rdata};
    assign m_tuser  = {out_res_reg.error, out_res_reg.start_valid};

    `DCRF_ASSERT_NEXT(a_advance_fills_output, advance, m_tvalid)
    `DCRF_ASSERT_NOW(a_start_without_error, m_tvalid && m_tuser[0], !m_tuser[1])
    `DCRF_ASSERT_NOW(a_rise_implies_level, m_tvalid && m_tdata[33], m_tdata[32])
    `DCRF_ASSERT_NOW(a_error_reads_zero, m_tvalid && m_tuser[1], m_tdata[31:0] == 32'd0)

endmodule
